### design/bftr_pkg.sv
// ----------------------------------------------------------------------------
// bftr_pkg
// Shared types, constants and the 5x7 font table of the text renderer.
// ----------------------------------------------------------------------------
package bftr_pkg;

  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int CELL_ADVANCE  = 6;
  localparam int GLYPH_BITS    = GLYPH_COLUMNS * GLYPH_ROWS;
  localparam int ROM_DEPTH     = 96;
  localparam int ENTRY_W       = $clog2(ROM_DEPTH);
  localparam int COORD_W       = 16;
  localparam int COLOUR_W      = 16;
  localparam int SCALE_W       = 4;
  localparam int COL_W         = $clog2(GLYPH_COLUMNS);

  localparam logic [7:0]         FIRST_PRINTABLE = 8'h20;
  localparam logic [7:0]         LAST_PRINTABLE  = 8'h7E;
  localparam logic [ENTRY_W-1:0] BOX_ENTRY       = ENTRY_W'(95);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOUR_W-1:0]       colour_t;
  typedef logic [SCALE_W-1:0]        scale_t;
  typedef logic [7:0]                char_t;
  typedef logic [GLYPH_COLUMNS-1:0]  glyph_row_t;
  typedef glyph_row_t [0:GLYPH_ROWS-1] glyph_t;
  typedef logic [GLYPH_BITS-1:0]     glyph_flat_t;

  typedef enum logic [0:0] {
    CFG_INK_COLOUR  = 1'b0,
    CFG_PIXEL_SCALE = 1'b1
  } cfg_index_t;

  // row bits: bit 4 is the leftmost column
  localparam glyph_t GLYPH_ROM [ROM_DEPTH] = '{
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04},
    '{5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h0A,5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h0A},
    '{5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04},
    '{5'h18,5'h19,5'h02,5'h04,5'h08,5'h13,5'h03},
    '{5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D},
    '{5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02},
    '{5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08},
    '{5'h00,5'h15,5'h0E,5'h1F,5'h0E,5'h15,5'h00},
    '{5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00},
    '{5'h00,5'h00,5'h00,5'h00,5'h0C,5'h04,5'h08},
    '{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00},
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C},
    '{5'h00,5'h01,5'h02,5'h04,5'h08,5'h10,5'h00},
    '{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
    '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
    '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
    '{5'h1F,5'h02,5'h06,5'h01,5'h01,5'h11,5'h0E},
    '{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
    '{5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
    '{5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E},
    '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
    '{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
    '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
    '{5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00},
    '{5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h04,5'h08},
    '{5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02},
    '{5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00},
    '{5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08},
    '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
    '{5'h0E,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0E},
    '{5'h04,5'h0A,5'h11,5'h11,5'h1F,5'h11,5'h11},
    '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
    '{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
    '{5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C},
    '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
    '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
    '{5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F},
    '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    '{5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    '{5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
    '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
    '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
    '{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
    '{5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11},
    '{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
    '{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
    '{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
    '{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
    '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
    '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11},
    '{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
    '{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
    '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
    '{5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E},
    '{5'h00,5'h10,5'h08,5'h04,5'h02,5'h01,5'h00},
    '{5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E},
    '{5'h04,5'h0A,5'h11,5'h00,5'h00,5'h00,5'h00},
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F},
    '{5'h08,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F},
    '{5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E},
    '{5'h00,5'h00,5'h0E,5'h11,5'h10,5'h11,5'h0E},
    '{5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F},
    '{5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E},
    '{5'h06,5'h09,5'h08,5'h1E,5'h08,5'h08,5'h08},
    '{5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h0E},
    '{5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h11},
    '{5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E},
    '{5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C},
    '{5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12},
    '{5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    '{5'h00,5'h00,5'h1A,5'h15,5'h15,5'h11,5'h11},
    '{5'h00,5'h00,5'h1E,5'h11,5'h11,5'h11,5'h11},
    '{5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E},
    '{5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10},
    '{5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h01},
    '{5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10},
    '{5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E},
    '{5'h08,5'h08,5'h1E,5'h08,5'h08,5'h09,5'h06},
    '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D},
    '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04},
    '{5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A},
    '{5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11},
    '{5'h00,5'h00,5'h11,5'h11,5'h0A,5'h04,5'h08},
    '{5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F},
    '{5'h03,5'h04,5'h04,5'h0C,5'h04,5'h04,5'h03},
    '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    '{5'h18,5'h04,5'h04,5'h06,5'h04,5'h04,5'h18},
    '{5'h00,5'h00,5'h0D,5'h12,5'h00,5'h00,5'h00},
    '{5'h1F,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1F}
  };

  // scan order: bit row*columns+col, leftmost column first
  function automatic glyph_flat_t glyph_flatten(glyph_t g);
    glyph_flat_t f;
    f = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLUMNS; c++) begin
        f[r*GLYPH_COLUMNS + c] = g[r][GLYPH_COLUMNS-1-c];
      end
    end
    return f;
  endfunction

  function automatic logic [ENTRY_W-1:0] glyph_entry(char_t code);
    logic [7:0] diff;
    diff = code - FIRST_PRINTABLE;
    if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE) begin
      return BOX_ENTRY;
    end
    return diff[ENTRY_W-1:0];
  endfunction

endpackage

### design/bitmap_font_text_renderer_core.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_core
// 5x7 character generator: looks up a glyph per character and emits one
// square fill rectangle per ink pixel, then advances the pen.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  char_code restart start_x start_y
//   out      output     out_valid/out_stall rect_x rect_y rect_size
//                                          fill_colour last_of_char
//   cfg      input      cfg_we             cfg_index cfg_wdata
//
// at accept the glyph rom word is read into a register; the scan then runs up
// to the last ink bit and closes with a step that advances the pen.
// the scan walks the registered glyph word one bit a cycle unless held.
// a stalled output holds the scan on an ink bit; blank bits keep moving.
// reset loads ink colour 0xffff, scale 1 and pen 0, 0.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bftr_pkg::char_t      in_char_code,
  input  logic                 in_restart,
  input  bftr_pkg::coord_t     in_start_x,
  input  bftr_pkg::coord_t     in_start_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bftr_pkg::coord_t     out_rect_x,
  output bftr_pkg::coord_t     out_rect_y,
  output bftr_pkg::scale_t     out_rect_size,
  output bftr_pkg::colour_t    out_fill_colour,
  output logic                 out_last_of_char,
  input  logic                 cfg_we,
  input  bftr_pkg::cfg_index_t cfg_index,
  input  bftr_pkg::colour_t    cfg_wdata
);
  import bftr_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                state_r;
  colour_t               ink_colour_r;
  scale_t                pixel_scale_r;
  scale_t                scale_r;
  logic [COORD_W-1:0]    pen_x_r;
  logic [COORD_W-1:0]    pen_y_r;
  logic [COORD_W-1:0]    cur_x_r;
  logic [COORD_W-1:0]    cur_y_r;
  logic [COL_W-1:0]      col_r;
  glyph_flat_t           glyph_r;

  logic                  out_valid_r;
  logic [COORD_W-1:0]    out_x_r;
  logic [COORD_W-1:0]    out_y_r;
  scale_t                out_size_r;
  colour_t               out_colour_r;
  logic                  out_last_r;

  logic                  in_accept;
  logic                  out_free;
  logic                  scan_done;
  logic                  ink_bit;
  logic                  step;
  scale_t                eff_scale;
  logic [COORD_W-1:0]    load_x;
  logic [COORD_W-1:0]    load_y;
  logic [COORD_W-1:0]    scale_ext;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign scan_done  = (glyph_r == '0);
  assign ink_bit    = glyph_r[0];
  assign step       = (state_r == ST_SCAN) && !scan_done && (!ink_bit || out_free);
  assign eff_scale  = (pixel_scale_r == '0) ? SCALE_W'(1) : pixel_scale_r;
  assign load_x     = in_restart ? in_start_x : pen_x_r;
  assign load_y     = in_restart ? in_start_y : pen_y_r;
  assign scale_ext  = {{(COORD_W-SCALE_W){1'b0}}, scale_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ink_colour_r  <= '1;
      pixel_scale_r <= SCALE_W'(1);
      pen_x_r       <= '0;
      pen_y_r       <= '0;
      out_valid_r   <= 1'b0;
      glyph_r       <= '0;
      col_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INK_COLOUR:  ink_colour_r  <= cfg_wdata;
          CFG_PIXEL_SCALE: pixel_scale_r <= cfg_wdata[SCALE_W-1:0];
        endcase
      end

      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            // glyph rom read, registered
            glyph_r <= glyph_flatten(GLYPH_ROM[glyph_entry(in_char_code)]);
            scale_r <= eff_scale;
            pen_x_r <= load_x;
            pen_y_r <= load_y;
            cur_x_r <= load_x;
            cur_y_r <= load_y;
            col_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            pen_x_r <= pen_x_r + COORD_W'(CELL_ADVANCE) * scale_ext;
            state_r <= ST_IDLE;
          end else if (step) begin
            if (ink_bit) begin
              out_valid_r  <= 1'b1;
              out_x_r      <= cur_x_r;
              out_y_r      <= cur_y_r;
              out_size_r   <= scale_r;
              out_colour_r <= ink_colour_r;
              out_last_r   <= (glyph_r[GLYPH_BITS-1:1] == '0);
            end
            glyph_r <= glyph_r >> 1;
            if (col_r == COL_W'(GLYPH_COLUMNS-1)) begin
              col_r   <= '0;
              cur_x_r <= pen_x_r;
              cur_y_r <= cur_y_r + scale_ext;
            end else begin
              col_r   <= col_r + COL_W'(1);
              cur_x_r <= cur_x_r + scale_ext;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rect_x       = out_x_r;
  assign out_rect_y       = out_y_r;
  assign out_rect_size    = out_size_r;
  assign out_fill_colour  = out_colour_r;
  assign out_last_of_char = out_last_r;

`ifndef NO_ASSERTIONS
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_done) |=> state_r == ST_IDLE)
    else $error("scan did not close after the last ink bit");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_SCAN)
    else $error("accepted item did not start a scan");

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_size_r != '0)
    else $error("rectangle of zero size");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(GLYPH_COLUMNS-1))
    else $error("column counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_x_r) && $stable(out_y_r)))
    else $error("pending rectangle overwritten");
`endif

endmodule
